@@ sv/logistic_regression_trainer_core_assert.svh @@
// Assertion macros shared by the checker files.
`ifndef LOGISTIC_REGRESSION_TRAINER_CORE_ASSERT_SVH
`define LOGISTIC_REGRESSION_TRAINER_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock, off during reset.
`define LRT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock, off during reset.
`define LRT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/lrt_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_pkg: shared types and constants of the logistic regression trainer
// Field widths, fixed-point formats, the command queue entry, back-end
// states and the sigmoid lookup table built at elaboration.
// ----------------------------------------------------------------------------
package lrt_pkg;

  localparam int FEATURES     = 8;
  localparam int FEAT_IDX_W   = 3;
  localparam int VALUE_W      = 16;
  localparam int WEIGHT_W     = 32;
  localparam int PROD_W       = WEIGHT_W + VALUE_W;       // w * x
  localparam int ACC_W        = PROD_W + FEAT_IDX_W;      // sum of FEATURES products
  localparam int SIG_ENTRIES  = 256;
  localparam int SIG_IDX_W    = 8;
  localparam int SIG_W        = 17;                       // unsigned Q1.16
  localparam int SIG_SPAN_LSB = 40;                       // 16.0 in the Q.36 dot product
  localparam int ERR_W        = SIG_W + 1;
  localparam int GP_W         = ERR_W + VALUE_W;
  localparam int GRAD_W       = 33;
  localparam int RATE_W       = 16;
  localparam int ITER_W       = 16;
  localparam int SP_W         = RATE_W + 1 + GRAD_W;
  localparam int STEP_SHIFT   = 20;
  localparam int STEP_W       = SP_W - STEP_SHIFT;
  localparam int CFG_IDX_W    = 4;
  localparam int CFG_DATA_W   = 16;

  localparam logic [FEAT_IDX_W-1:0] FEAT_LAST = FEAT_IDX_W'(FEATURES - 1);

  localparam logic [CFG_IDX_W-1:0] REG_ITERATION_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_LEARNING_RATE   = CFG_IDX_W'(1);

  localparam logic [ITER_W-1:0] ITER_RESET = ITER_W'(100);
  localparam logic [RATE_W-1:0] RATE_RESET = RATE_W'(6554);

  localparam logic KIND_WEIGHTS = 1'b1;

  localparam logic signed [ACC_W:0]   SIG_BIAS  = (ACC_W + 1)'(1) << (SIG_SPAN_LSB - 1);
  localparam logic signed [ERR_W-1:0] ERR_ONE   = ERR_W'(65536);
  localparam logic signed [SP_W-1:0]  STEP_BIAS = SP_W'((1 << STEP_SHIFT) - 1);

  typedef enum logic [1:0] {
    OP_WEIGHTS,
    OP_SAMPLE,
    OP_DROP
  } op_e;

  typedef logic [FEATURES-1:0][VALUE_W-1:0] values_t;

  typedef struct packed {
    op_e     op;
    values_t values;
    logic    label;
    logic    last;
    logic    ovf;
  } entry_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_ITER,
    ST_READ,
    ST_LOAD,
    ST_DOT,
    ST_DOT_TAIL,
    ST_IDX,
    ST_SIG,
    ST_GRAD,
    ST_GRAD_TAIL,
    ST_DIV_START,
    ST_DIV_WAIT,
    ST_STEP,
    ST_UPDATE,
    ST_EMIT
  } back_state_e;

  typedef logic [SIG_ENTRIES-1:0][SIG_W-1:0] sig_tab_t;

  // shift-and-subtract quotient for the table build
  function automatic longint unsigned udiv64(longint unsigned n, longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    int              b;
    q = 0;
    r = 0;
    for (b = 63; b >= 0; b--) begin
      r = (r << 1) | ((n >> b) & 64'd1);
      if (r >= d) begin
        r = r - d;
        q = q | (64'd1 << b);
      end
    end
    return q;
  endfunction

  // sigmoid at the center of each table bin, exp(-|z|) as (series of e^(-|z|/8))^8
  function automatic sig_tab_t build_sig_table();
    sig_tab_t            tab;
    longint              z;
    longint              sum;
    longint unsigned     mag;
    longint unsigned     u;
    longint unsigned     term;
    longint unsigned     e;
    longint unsigned     den;
    longint unsigned     num;
    longint unsigned     one;
    int                  i;
    int                  k;
    one = 64'd1 << 30;
    for (i = 0; i < SIG_ENTRIES; i++) begin
      z = longint'((longint'(2 * i + 1) << 33) / SIG_ENTRIES) - (longint'(1) << 33);
      mag = (z < 0) ? longint'(-z) : z;
      u = mag >> 3;
      term = one;
      sum = longint'(one);
      for (k = 1; k <= 16; k++) begin
        term = udiv64((term * u) >> 30, longint'(k));
        if (k % 2 == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      for (k = 0; k < 3; k++) begin
        sum = longint'((longint'(sum) * longint'(sum)) >> 30);
      end
      e = sum;
      den = one + e;
      num = (z < 0) ? (e << 16) : (one << 16);
      tab[i] = SIG_W'(udiv64(num + den / 2, den));
    end
    return tab;
  endfunction

  localparam sig_tab_t SIG_TABLE = build_sig_table();

endpackage

@@ sv/lrt_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module lrt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                        wdata_i,
  input  logic                                    re_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                        rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

@@ sv/lrt_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_queue: two-entry command queue between front and back end
// Full and empty come straight from registers.
// ----------------------------------------------------------------------------
module lrt_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lrt_pkg::entry_t entry_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output lrt_pkg::entry_t head_o
);

  lrt_pkg::entry_t slot_q [2];
  logic            wptr_q;
  logic            rptr_q;
  logic [1:0]      count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = slot_q[rptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push_i) begin
        wptr_q <= ~wptr_q;
      end
      if (pop_i) begin
        rptr_q <= ~rptr_q;
      end
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

@@ sv/lrt_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_front: input classifier
// Tags each item as weight load, stored sample or dropped sample, tracks the
// batch fill and overflow, and pushes the tagged item into the queue.
// ----------------------------------------------------------------------------
module lrt_front #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  lrt_pkg::values_t        values_i,
  input  logic                    label_i,
  input  logic                    last_i,
  input  logic                    full_i,
  output logic                    push_o,
  output lrt_pkg::entry_t         entry_o
);

  localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

  logic [CNT_W-1:0] fill_q;
  logic             ovf_q;
  lrt_pkg::op_e     op;

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    if (kind_i == lrt_pkg::KIND_WEIGHTS) begin
      op = lrt_pkg::OP_WEIGHTS;
    end else if (fill_q < CNT_W'(MAX_SAMPLES)) begin
      op = lrt_pkg::OP_SAMPLE;
    end else begin
      op = lrt_pkg::OP_DROP;
    end
    entry_o.op     = op;
    entry_o.values = values_i;
    entry_o.label  = label_i;
    entry_o.last   = last_i;
    entry_o.ovf    = ovf_q || (op == lrt_pkg::OP_DROP);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      ovf_q  <= 1'b0;
    end else if (push_o) begin
      if (last_i) begin
        // batch closes: the back end clears its count after emission
        fill_q <= '0;
        ovf_q  <= 1'b0;
      end else if (op == lrt_pkg::OP_SAMPLE) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (op == lrt_pkg::OP_DROP) begin
        ovf_q <= 1'b1;
      end
    end
  end

endmodule

@@ sv/lrt_div.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_div: iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ----------------------------------------------------------------------------
module lrt_div #(
  parameter int DW = 43,
  parameter int VW = 9
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic signed [DW-1:0]  dividend_i,
  input  logic [VW-1:0]         divisor_i,
  output lrt_pkg::div_status_t  status_o,
  output logic signed [DW-1:0]  quotient_o
);

  localparam int CW = $clog2(DW + 1);

  logic          busy_q;
  logic          done_q;
  logic [CW-1:0] cnt_q;
  logic          neg_q;
  logic [DW-1:0] quot_q;
  logic [VW:0]   rem_q;
  logic [VW-1:0] dvs_q;
  logic [VW:0]   rem_sh;
  logic          fits;

  always_comb begin
    rem_sh = {rem_q[VW-1:0], quot_q[DW-1]};
    fits   = (rem_sh >= {1'b0, dvs_q});
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = neg_q ? -$signed(quot_q) : $signed(quot_q);

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q  <= dividend_i[DW-1];
      quot_q <= dividend_i[DW-1] ? DW'(-dividend_i) : DW'(dividend_i);
      rem_q  <= '0;
      dvs_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= fits ? (rem_sh - {1'b0, dvs_q}) : rem_sh;
      quot_q <= {quot_q[DW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

@@ sv/lrt_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_back: training engine
// Stores samples, loads weights, runs the gradient descent passes with
// multiply-accumulate steps and an iterative divider, and emits the weights.
// ----------------------------------------------------------------------------
module lrt_back #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 empty_i,
  input  lrt_pkg::entry_t                      head_i,
  output logic                                 pop_o,
  input  logic [lrt_pkg::ITER_W-1:0]           iter_i,
  input  logic [lrt_pkg::RATE_W-1:0]           rate_i,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic [lrt_pkg::FEAT_IDX_W-1:0]       weight_index_o,
  output logic signed [lrt_pkg::WEIGHT_W-1:0]  weight_value_o,
  output logic                                 overflow_o,
  output logic                                 last_result_o
);

  localparam int CNT_W  = $clog2(MAX_SAMPLES + 1);
  localparam int ADDR_W = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
  localparam int SUM_W  = lrt_pkg::GP_W + CNT_W;
  localparam int RAM_W  = lrt_pkg::FEATURES * lrt_pkg::VALUE_W + 1;

  lrt_pkg::back_state_e state_q, state_d;

  lrt_pkg::entry_t cur_q;
  logic signed [lrt_pkg::WEIGHT_W-1:0] weights_q [lrt_pkg::FEATURES];
  logic signed [SUM_W-1:0]             sums_q [lrt_pkg::FEATURES];
  logic signed [lrt_pkg::VALUE_W-1:0]  x_q [lrt_pkg::FEATURES];
  logic                                lab_q;
  logic [CNT_W-1:0]                    cnt_q;
  logic [CNT_W-1:0]                    s_q;
  logic [lrt_pkg::ITER_W-1:0]          it_q;
  logic [lrt_pkg::FEAT_IDX_W-1:0]      f_q;
  logic [lrt_pkg::FEAT_IDX_W-1:0]      gf_q;
  logic                                pv_q;
  logic                                ovf_q;
  logic signed [lrt_pkg::PROD_W-1:0]   prod_q;
  logic signed [lrt_pkg::ACC_W-1:0]    acc_q;
  logic [lrt_pkg::SIG_IDX_W-1:0]       idx_q;
  logic signed [lrt_pkg::ERR_W-1:0]    err_q;
  logic signed [lrt_pkg::GP_W-1:0]     gp_q;
  logic signed [lrt_pkg::GRAD_W-1:0]   grad_q;
  logic signed [lrt_pkg::SP_W-1:0]     sp_q;

  logic                                out_valid_q;
  logic [lrt_pkg::FEAT_IDX_W-1:0]      weight_index_q;
  logic signed [lrt_pkg::WEIGHT_W-1:0] weight_value_q;
  logic                                overflow_q;
  logic                                last_result_q;

  logic                          ram_we;
  logic                          ram_re;
  logic [RAM_W-1:0]              ram_rdata;
  logic                          div_start;
  lrt_pkg::div_status_t          div_status;
  logic signed [SUM_W-1:0]       div_quot;
  logic                          ld_out;
  logic                          is_sample;
  logic signed [lrt_pkg::ACC_W:0] off;
  logic [lrt_pkg::SIG_IDX_W-1:0] idx_d;
  logic signed [lrt_pkg::SP_W-1:0]   sp_adj;
  logic signed [lrt_pkg::STEP_W-1:0] step;
  logic signed [lrt_pkg::WEIGHT_W:0] wnew;
  logic signed [lrt_pkg::WEIGHT_W-1:0] wsat;

  lrt_ram #(
    .WIDTH (RAM_W),
    .DEPTH (MAX_SAMPLES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (cnt_q[ADDR_W-1:0]),
    .wdata_i ({cur_q.label, cur_q.values}),
    .re_i    (ram_re),
    .raddr_i (s_q[ADDR_W-1:0]),
    .rdata_o (ram_rdata)
  );

  lrt_div #(
    .DW (SUM_W),
    .VW (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (sums_q[f_q]),
    .divisor_i  (cnt_q),
    .status_o   (div_status),
    .quotient_o (div_quot)
  );

  assign is_sample = (cur_q.op == lrt_pkg::OP_SAMPLE);
  assign ld_out    = (state_q == lrt_pkg::ST_EMIT) && (!out_valid_q || !out_stall_i);

  // sigmoid index: saturate below -8 and at or above +8
  always_comb begin
    off = (lrt_pkg::ACC_W + 1)'(acc_q) + lrt_pkg::SIG_BIAS;
    if (off[lrt_pkg::ACC_W]) begin
      idx_d = '0;
    end else if (off[lrt_pkg::ACC_W-1:lrt_pkg::SIG_SPAN_LSB] != '0) begin
      idx_d = '1;
    end else begin
      idx_d = off[lrt_pkg::SIG_SPAN_LSB-1 -: lrt_pkg::SIG_IDX_W];
    end
  end

  // weight update: step truncated toward zero, result saturated
  always_comb begin
    sp_adj = sp_q[lrt_pkg::SP_W-1] ? (sp_q + lrt_pkg::STEP_BIAS) : sp_q;
    step   = lrt_pkg::STEP_W'(sp_adj >>> lrt_pkg::STEP_SHIFT);
    wnew   = (lrt_pkg::WEIGHT_W + 1)'(weights_q[f_q]) - (lrt_pkg::WEIGHT_W + 1)'(step);
    if (wnew[lrt_pkg::WEIGHT_W] != wnew[lrt_pkg::WEIGHT_W-1]) begin
      wsat = wnew[lrt_pkg::WEIGHT_W] ? {1'b1, {(lrt_pkg::WEIGHT_W - 1){1'b0}}}
                                     : {1'b0, {(lrt_pkg::WEIGHT_W - 1){1'b1}}};
    end else begin
      wsat = wnew[lrt_pkg::WEIGHT_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lrt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    pop_o     = 1'b0;
    ram_we    = 1'b0;
    ram_re    = 1'b0;
    div_start = 1'b0;
    unique case (state_q)
      lrt_pkg::ST_IDLE: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          state_d = lrt_pkg::ST_EXEC;
        end
      end
      lrt_pkg::ST_EXEC: begin
        ram_we = is_sample;
        if (!cur_q.last) begin
          state_d = lrt_pkg::ST_IDLE;
        end else if ((is_sample || cnt_q != '0) && iter_i != '0) begin
          state_d = lrt_pkg::ST_ITER;
        end else begin
          state_d = lrt_pkg::ST_EMIT;
        end
      end
      lrt_pkg::ST_ITER:  state_d = lrt_pkg::ST_READ;
      lrt_pkg::ST_READ: begin
        ram_re  = 1'b1;
        state_d = lrt_pkg::ST_LOAD;
      end
      lrt_pkg::ST_LOAD:  state_d = lrt_pkg::ST_DOT;
      lrt_pkg::ST_DOT: begin
        if (f_q == lrt_pkg::FEAT_LAST) begin
          state_d = lrt_pkg::ST_DOT_TAIL;
        end
      end
      lrt_pkg::ST_DOT_TAIL: state_d = lrt_pkg::ST_IDX;
      lrt_pkg::ST_IDX:      state_d = lrt_pkg::ST_SIG;
      lrt_pkg::ST_SIG:      state_d = lrt_pkg::ST_GRAD;
      lrt_pkg::ST_GRAD: begin
        if (f_q == lrt_pkg::FEAT_LAST) begin
          state_d = lrt_pkg::ST_GRAD_TAIL;
        end
      end
      lrt_pkg::ST_GRAD_TAIL: begin
        if (s_q + CNT_W'(1) == cnt_q) begin
          state_d = lrt_pkg::ST_DIV_START;
        end else begin
          state_d = lrt_pkg::ST_READ;
        end
      end
      lrt_pkg::ST_DIV_START: begin
        div_start = 1'b1;
        state_d   = lrt_pkg::ST_DIV_WAIT;
      end
      lrt_pkg::ST_DIV_WAIT: begin
        if (div_status.done) begin
          state_d = lrt_pkg::ST_STEP;
        end
      end
      lrt_pkg::ST_STEP: state_d = lrt_pkg::ST_UPDATE;
      lrt_pkg::ST_UPDATE: begin
        if (f_q != lrt_pkg::FEAT_LAST) begin
          state_d = lrt_pkg::ST_DIV_START;
        end else if (it_q + lrt_pkg::ITER_W'(1) == iter_i) begin
          state_d = lrt_pkg::ST_EMIT;
        end else begin
          state_d = lrt_pkg::ST_ITER;
        end
      end
      lrt_pkg::ST_EMIT: begin
        if (ld_out && f_q == lrt_pkg::FEAT_LAST) begin
          state_d = lrt_pkg::ST_IDLE;
        end
      end
      default: state_d = lrt_pkg::ST_IDLE;
    endcase
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      lrt_pkg::ST_IDLE: begin
        if (!empty_i) begin
          cur_q <= head_i;
        end
      end
      lrt_pkg::ST_EXEC: begin
        f_q  <= '0;
        it_q <= '0;
        ovf_q <= cur_q.ovf;
      end
      lrt_pkg::ST_ITER: begin
        s_q <= '0;
        for (int i = 0; i < lrt_pkg::FEATURES; i++) begin
          sums_q[i] <= '0;
        end
      end
      lrt_pkg::ST_LOAD: begin
        for (int i = 0; i < lrt_pkg::FEATURES; i++) begin
          x_q[i] <= ram_rdata[i*lrt_pkg::VALUE_W +: lrt_pkg::VALUE_W];
        end
        lab_q <= ram_rdata[RAM_W-1];
        f_q   <= '0;
        pv_q  <= 1'b0;
        acc_q <= '0;
      end
      lrt_pkg::ST_DOT: begin
        prod_q <= weights_q[f_q] * x_q[f_q];
        if (pv_q) begin
          acc_q <= acc_q + lrt_pkg::ACC_W'(prod_q);
        end
        pv_q <= 1'b1;
        f_q  <= f_q + lrt_pkg::FEAT_IDX_W'(1);
      end
      lrt_pkg::ST_DOT_TAIL: acc_q <= acc_q + lrt_pkg::ACC_W'(prod_q);
      lrt_pkg::ST_IDX:      idx_q <= idx_d;
      lrt_pkg::ST_SIG: begin
        err_q <= $signed({1'b0, lrt_pkg::SIG_TABLE[idx_q]})
                 - (lab_q ? lrt_pkg::ERR_ONE : '0);
        f_q  <= '0;
        pv_q <= 1'b0;
      end
      lrt_pkg::ST_GRAD: begin
        gp_q <= err_q * x_q[f_q];
        gf_q <= f_q;
        if (pv_q) begin
          sums_q[gf_q] <= sums_q[gf_q] + SUM_W'(gp_q);
        end
        pv_q <= 1'b1;
        f_q  <= f_q + lrt_pkg::FEAT_IDX_W'(1);
      end
      lrt_pkg::ST_GRAD_TAIL: begin
        sums_q[gf_q] <= sums_q[gf_q] + SUM_W'(gp_q);
        s_q <= s_q + CNT_W'(1);
        f_q <= '0;
      end
      lrt_pkg::ST_DIV_WAIT: begin
        if (div_status.done) begin
          grad_q <= div_quot[lrt_pkg::GRAD_W-1:0];
        end
      end
      lrt_pkg::ST_STEP: sp_q <= $signed({1'b0, rate_i}) * grad_q;
      lrt_pkg::ST_UPDATE: begin
        f_q <= f_q + lrt_pkg::FEAT_IDX_W'(1);
        if (f_q == lrt_pkg::FEAT_LAST) begin
          it_q <= it_q + lrt_pkg::ITER_W'(1);
        end
      end
      lrt_pkg::ST_EMIT: begin
        if (ld_out) begin
          f_q <= f_q + lrt_pkg::FEAT_IDX_W'(1);
        end
      end
      default: ;
    endcase
  end

  // weights and sample count carry architectural reset values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < lrt_pkg::FEATURES; i++) begin
        weights_q[i] <= '0;
      end
      cnt_q <= '0;
    end else begin
      if (state_q == lrt_pkg::ST_EXEC) begin
        if (cur_q.op == lrt_pkg::OP_WEIGHTS) begin
          for (int i = 0; i < lrt_pkg::FEATURES; i++) begin
            weights_q[i] <= {cur_q.values[i], 16'h0000};
          end
        end
        if (is_sample) begin
          cnt_q <= cnt_q + CNT_W'(1);
        end
      end
      if (state_q == lrt_pkg::ST_UPDATE) begin
        weights_q[f_q] <= wsat;
      end
      if (ld_out && f_q == lrt_pkg::FEAT_LAST) begin
        cnt_q <= '0;
      end
    end
  end

  // output register: load when empty or being taken
  always_ff @(posedge clk_i) begin
    if (ld_out) begin
      weight_index_q <= f_q;
      weight_value_q <= weights_q[f_q];
      overflow_q     <= ovf_q;
      last_result_q  <= (f_q == lrt_pkg::FEAT_LAST);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ld_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign weight_index_o = weight_index_q;
  assign weight_value_o = weight_value_q;
  assign overflow_o     = overflow_q;
  assign last_result_o  = last_result_q;

endmodule

@@ sv/logistic_regression_trainer_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// logistic_regression_trainer_core: full-batch logistic regression trainer
// Loads samples or an initial weight vector, trains on the last item and
// reports the eight trained weights.
// ----------------------------------------------------------------------------
// Input channel (in_valid_i / in_stall_o): one item per accepted beat, either
// a sample (kind 0) or a weight vector (kind 1); last 1 starts training.
// A two-entry queue sits between the input classifier and the engine, so
// items are taken while the engine works; the engine passes a load item
// through its idle and execute states. Gradient sums are SUM_W bits, with
// SUM_W = 34 + clog2(MAX_SAMPLES + 1). Per sample an iteration does one
// memory read, a multiply-accumulate pass for the dot product, then one for
// the gradient; per weight, one bit-serial divide and a rate multiply.
// Output channel (out_valid_o / out_stall_i): eight results, index 0 to 7,
// from one output register; a stall holds the register and the engine.
// Configuration (cfg_valid_i / cfg_ready_o) always ready: index 0 writes the
// iteration count, index 1 the learning rate; write only while idle.
// Reset clears weights, counts and control; sample memory needs no clearing.
// ----------------------------------------------------------------------------
module logistic_regression_trainer_core #(
  parameter int MAX_SAMPLES = 256
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lrt_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [lrt_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                kind_i,
  input  logic signed [15:0]                  value_0_i,
  input  logic signed [15:0]                  value_1_i,
  input  logic signed [15:0]                  value_2_i,
  input  logic signed [15:0]                  value_3_i,
  input  logic signed [15:0]                  value_4_i,
  input  logic signed [15:0]                  value_5_i,
  input  logic signed [15:0]                  value_6_i,
  input  logic signed [15:0]                  value_7_i,
  input  logic                                label_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [2:0]                          weight_index_o,
  output logic signed [31:0]                  weight_value_o,
  output logic                                overflow_o,
  output logic                                last_result_o
);

  logic [lrt_pkg::ITER_W-1:0] iter_q;
  logic [lrt_pkg::RATE_W-1:0] rate_q;
  lrt_pkg::values_t           values;
  lrt_pkg::entry_t            push_entry;
  lrt_pkg::entry_t            head;
  logic                       push;
  logic                       pop;
  logic                       full;
  logic                       empty;

  assign cfg_ready_o = 1'b1;
  assign values = {value_7_i, value_6_i, value_5_i, value_4_i,
                   value_3_i, value_2_i, value_1_i, value_0_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iter_q <= lrt_pkg::ITER_RESET;
      rate_q <= lrt_pkg::RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        lrt_pkg::REG_ITERATION_COUNT: iter_q <= cfg_data_i;
        lrt_pkg::REG_LEARNING_RATE:   rate_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  lrt_front #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .kind_i     (kind_i),
    .values_i   (values),
    .label_i    (label_i),
    .last_i     (last_i),
    .full_i     (full),
    .push_o     (push),
    .entry_o    (push_entry)
  );

  lrt_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head)
  );

  lrt_back #(
    .MAX_SAMPLES (MAX_SAMPLES)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .empty_i        (empty),
    .head_i         (head),
    .pop_o          (pop),
    .iter_i         (iter_q),
    .rate_i         (rate_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .weight_index_o (weight_index_o),
    .weight_value_o (weight_value_o),
    .overflow_o     (overflow_o),
    .last_result_o  (last_result_o)
  );

endmodule

@@ sv/lrt_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrt_checker: port-level checks of the trainer
// Watches the result channel for ordering and hold behavior.
// ----------------------------------------------------------------------------
`include "logistic_regression_trainer_core_assert.svh"

module lrt_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           out_valid_o,
  input logic                           out_stall_i,
  input logic [2:0]                     weight_index_o,
  input logic signed [31:0]             weight_value_o,
  input logic                           last_result_o
);

  // stalled result holds
  `LRT_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i,
    out_valid_o && $stable(weight_value_o) && $stable(weight_index_o), "stalled result changed")

  // the final result of a batch is exactly the last weight index
  `LRT_ASSERT_NOW(a_last_index, out_valid_o,
    last_result_o == (weight_index_o == 3'd7), "last_result does not match index")

  // weights of one batch come out in index order
  `LRT_ASSERT_NEXT(a_index_order, out_valid_o && !out_stall_i && !last_result_o,
    !out_valid_o || weight_index_o == $past(weight_index_o) + 3'd1, "weight index skipped")

endmodule

bind logistic_regression_trainer_core lrt_checker u_lrt_checker (.*);
